// File: sv/hbf_pkg.sv
// Shared types, constants and CRC function for the HDLC bit framer.
`timescale 1ns / 1ps

package hbf_pkg;

	localparam int MAX_PREAMBLE = 16;
	localparam int PRE_W = 5;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [7:0] FLAG = 8'h7E;

	localparam logic [2:0] ADDR_PREAMBLE = 3'd0;

	typedef struct packed {
		logic [7:0] data;
		logic last;
		logic first;
		logic [PRE_W-1:0] pre;
		logic [15:0] fcs;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: sv/hbf_front.sv
// Front end: accepts payload bytes, tracks frame state and CRC, builds queue entries.
`timescale 1ns / 1ps

module hbf_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] data_byte,
	input  logic last_byte,
	input  logic [hbf_pkg::PRE_W-1:0] preamble_zeros,
	input  hbf_pkg::qstat_t qstat,
	output logic push,
	output hbf_pkg::item_t push_item
);

	logic inside_q;
	logic [15:0] crc_q;
	logic [15:0] crc_start;
	logic [15:0] crc_next;
	logic [hbf_pkg::PRE_W-1:0] pre_sat;

	assign in_ready = !qstat.full;
	assign push = in_valid && in_ready;

	assign crc_start = inside_q ? crc_q : hbf_pkg::CRC_INIT;
	assign crc_next = hbf_pkg::crc_byte(crc_start, data_byte);
	assign pre_sat = (preamble_zeros > hbf_pkg::PRE_W'(hbf_pkg::MAX_PREAMBLE)) ?
		hbf_pkg::PRE_W'(hbf_pkg::MAX_PREAMBLE) : preamble_zeros;

	always_comb begin
		push_item.data = data_byte;
		push_item.last = last_byte;
		push_item.first = !inside_q;
		push_item.pre = pre_sat;
		push_item.fcs = crc_next ^ hbf_pkg::CRC_INIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			crc_q <= hbf_pkg::CRC_INIT;
		end else if (push) begin
			if (last_byte) begin
				inside_q <= 1'b0;
				crc_q <= hbf_pkg::CRC_INIT;
			end else begin
				inside_q <= 1'b1;
				crc_q <= crc_next;
			end
		end
	end

endmodule

// File: sv/hbf_queue.sv
// Short queue of classified bytes between front end and serializer.
`timescale 1ns / 1ps

module hbf_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  hbf_pkg::item_t push_item,
	input  logic pop,
	output hbf_pkg::item_t pop_item,
	output hbf_pkg::qstat_t qstat
);

	hbf_pkg::item_t mem_q [hbf_pkg::QDEPTH];
	logic [hbf_pkg::QPTR_W-1:0] wptr_q;
	logic [hbf_pkg::QPTR_W-1:0] rptr_q;
	logic [hbf_pkg::QCNT_W-1:0] cnt_q;

	assign qstat.full = (cnt_q == hbf_pkg::QCNT_W'(hbf_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == hbf_pkg::QPTR_W'(hbf_pkg::QDEPTH - 1)) ? '0 :
					wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == hbf_pkg::QPTR_W'(hbf_pkg::QDEPTH - 1)) ? '0 :
					rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/hbf_serializer.sv
// Back end: emits preamble, flags, payload and FCS bits with zero stuffing.
`timescale 1ns / 1ps

module hbf_serializer (
	input  logic clk,
	input  logic arst_n,
	input  hbf_pkg::qstat_t qstat,
	input  hbf_pkg::item_t pop_item,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic out_bit,
	output logic frame_start,
	output logic run_last
);

	typedef enum logic [2:0] {
		IDLE, PRE, OFLAG, DATA, FCS_LO, FCS_HI, CFLAG, ENDP
	} phase_t;

	phase_t phase_q, phase_d;
	logic [4:0] cnt_q, cnt_d;
	logic stuff_q, stuff_d;
	logic [2:0] ones_q, ones_d;
	logic spend_q, spend_d;
	logic [7:0] sh_q;
	logic last_q;
	logic [15:0] fcs_q;
	logic [hbf_pkg::PRE_W-1:0] pre_q;
	logic ovalid_q, obit_q, ostart_q, olast_q;

	logic adv, emit, load, content;
	logic e_bit, e_start, e_end;

	assign adv = !ovalid_q || out_ready;
	assign emit = adv && (phase_q != IDLE);
	assign load = !qstat.empty && ((phase_q == IDLE) || (emit && e_end));
	assign pop = load;

	assign out_valid = ovalid_q;
	assign out_bit = obit_q;
	assign frame_start = ostart_q;
	assign run_last = olast_q;

	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		stuff_d = stuff_q;
		ones_d = ones_q;
		spend_d = spend_q;
		e_bit = 1'b0;
		e_start = 1'b0;
		e_end = 1'b0;
		content = 1'b0;
		if (stuff_q) begin
			stuff_d = 1'b0;
			ones_d = '0;
			e_end = (phase_q == ENDP);
		end else begin
			case (phase_q)
				PRE: begin
					e_start = spend_q;
					spend_d = 1'b0;
					if (cnt_q == pre_q - 5'd1) begin
						phase_d = OFLAG;
						cnt_d = '0;
					end else begin
						cnt_d = cnt_q + 5'd1;
					end
				end
				OFLAG, CFLAG: begin
					e_bit = hbf_pkg::FLAG[cnt_q[2:0]];
					e_start = spend_q;
					spend_d = 1'b0;
					cnt_d = cnt_q + 5'd1;
					if (cnt_q[2:0] == 3'd7) begin
						cnt_d = '0;
						if (phase_q == OFLAG) begin
							phase_d = DATA;
						end else begin
							e_end = 1'b1;
							ones_d = '0;
						end
					end
				end
				DATA: begin
					e_bit = sh_q[cnt_q[2:0]];
					content = 1'b1;
				end
				FCS_LO: begin
					e_bit = fcs_q[cnt_q[2:0]];
					content = 1'b1;
				end
				FCS_HI: begin
					e_bit = fcs_q[{1'b1, cnt_q[2:0]}];
					content = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (content) begin
			if (e_bit) begin
				if (ones_q == 3'd4) begin
					ones_d = '0;
					stuff_d = 1'b1;
				end else begin
					ones_d = ones_q + 3'd1;
				end
			end else begin
				ones_d = '0;
			end
			cnt_d = cnt_q + 5'd1;
			if (cnt_q[2:0] == 3'd7) begin
				cnt_d = '0;
				case (phase_q)
					DATA: begin
						if (last_q) begin
							phase_d = FCS_LO;
						end else if (stuff_d) begin
							phase_d = ENDP;
						end else begin
							e_end = 1'b1;
						end
					end
					FCS_LO: phase_d = FCS_HI;
					default: phase_d = CFLAG;
				endcase
			end
		end
		if (e_end) begin
			phase_d = IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= IDLE;
			cnt_q <= '0;
			stuff_q <= 1'b0;
			ones_q <= '0;
			spend_q <= 1'b0;
			sh_q <= '0;
			last_q <= 1'b0;
			fcs_q <= '0;
			pre_q <= '0;
			ovalid_q <= 1'b0;
			obit_q <= 1'b0;
			ostart_q <= 1'b0;
			olast_q <= 1'b0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
				obit_q <= e_bit;
				ostart_q <= e_start;
				olast_q <= e_end;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (load) begin
				cnt_q <= '0;
				stuff_q <= 1'b0;
				sh_q <= pop_item.data;
				last_q <= pop_item.last;
				fcs_q <= pop_item.fcs;
				pre_q <= pop_item.pre;
				spend_q <= pop_item.first;
				if (pop_item.first) begin
					ones_q <= '0;
					phase_q <= (pop_item.pre == '0) ? OFLAG : PRE;
				end else begin
					ones_q <= ones_d;
					phase_q <= DATA;
				end
			end else if (emit) begin
				phase_q <= phase_d;
				cnt_q <= cnt_d;
				stuff_q <= stuff_d;
				ones_q <= ones_d;
				spend_q <= spend_d;
			end
		end
	end

endmodule

// File: sv/hdlc_bit_framer.sv
// Top level of the HDLC bit framer: register port, front end, queue, serializer.
// Throughput: one line bit per cycle from the serializer while out_ready is high
// and the queue is not empty; a byte goes out as its 8 data bits and any stuffed
// zeros, plus preamble and opening flag on a first byte, plus FCS and flag on a
// last.
// Reset clears the register, frame state, CRC, queue and serializer at once.
`timescale 1ns / 1ps

module hdlc_bit_framer (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] data_byte,
	input  logic last_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic out_bit,
	output logic frame_start,
	output logic run_last
);

	logic [hbf_pkg::PRE_W-1:0] preamble_q;
	logic push, pop;
	hbf_pkg::item_t push_item, pop_item;
	hbf_pkg::qstat_t qstat;
	logic sel_pre;

	assign pready = 1'b1;
	assign sel_pre = ({paddr[2], 2'b00} == hbf_pkg::ADDR_PREAMBLE);
	assign prdata = sel_pre ? {{(32 - hbf_pkg::PRE_W){1'b0}}, preamble_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= '0;
		end else if (psel && penable && pwrite && pready && sel_pre) begin
			preamble_q <= pwdata[hbf_pkg::PRE_W-1:0];
		end
	end

	hbf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.preamble_zeros(preamble_q),
		.qstat(qstat),
		.push(push),
		.push_item(push_item)
	);

	hbf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.pop_item(pop_item),
		.qstat(qstat)
	);

	hbf_serializer u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.pop_item(pop_item),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_bit(out_bit),
		.frame_start(frame_start),
		.run_last(run_last)
	);

endmodule

// File: sv/hbf_checker.sv
// Port-level checks for the HDLC bit framer, bound to the top level.
`timescale 1ns / 1ps

module hbf_checker (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic pready,
	input logic in_valid,
	input logic in_ready,
	input logic [7:0] data_byte,
	input logic last_byte,
	input logic out_valid,
	input logic out_ready,
	input logic out_bit,
	input logic frame_start,
	input logic run_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bit) &&
		$stable(frame_start) && $stable(run_last))
		else $error("output transfer dropped or changed while stalled");

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_start |-> !out_bit)
		else $error("frame start on a one bit");

	a_start_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_start |-> !run_last)
		else $error("frame start on the last bit of a byte");

	a_prdata_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> prdata[31:5] == 27'd0)
		else $error("read data beyond register width");

endmodule

bind hdlc_bit_framer hbf_checker u_hbf_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the HDLC bit framer: line-bit prediction, stuffing, CRC, preamble.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

	class line_bit_board;
		typedef struct packed {
			logic out_bit;
			logic frame_start;
			logic run_last;
		} line_bit_t;

		line_bit_t due[$];
		logic [15:0] crc;
		logic [2:0] ones;
		bit in_frame;
		logic [4:0] pre_reg;
		int errors;
		int checked;
		int bytes_in;
		int frames;

		function new();
			crc = hbf_pkg::CRC_INIT;
			ones = 0;
			in_frame = 0;
			pre_reg = 0;
			errors = 0;
			checked = 0;
			bytes_in = 0;
			frames = 0;
		endfunction

		static function logic [15:0] crc_after(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {8'h00, b};
			for (int i = 0; i < 8; i++) begin
				if (r[0])
					r = (r >> 1) ^ hbf_pkg::CRC_POLY;
				else
					r = r >> 1;
			end
			return r;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("ERROR: %s", msg);
		endfunction

		function void set_preamble(logic [31:0] v);
			pre_reg = v[4:0];
		endfunction

		function void push_bit(logic b, logic s);
			line_bit_t lb;
			lb.out_bit = b;
			lb.frame_start = s;
			lb.run_last = 1'b0;
			due.push_back(lb);
		endfunction

		function void push_content(logic b);
			push_bit(b, 1'b0);
			if (b) begin
				ones++;
				if (ones >= 5) begin
					push_bit(1'b0, 1'b0);
					ones = 0;
				end
			end else begin
				ones = 0;
			end
		endfunction

		function void note_byte(logic [7:0] d, logic l);
			int n;
			logic [15:0] fcs;
			line_bit_t tail;
			bytes_in++;
			if (!in_frame) begin
				n = (pre_reg > hbf_pkg::MAX_PREAMBLE) ? hbf_pkg::MAX_PREAMBLE : int'(pre_reg);
				for (int i = 0; i < n; i++)
					push_bit(1'b0, i == 0);
				for (int i = 0; i < 8; i++)
					push_bit(hbf_pkg::FLAG[i], n == 0 && i == 0);
				in_frame = 1;
				ones = 0;
				crc = hbf_pkg::CRC_INIT;
				frames++;
			end
			crc = crc_after(crc, d);
			for (int i = 0; i < 8; i++)
				push_content(d[i]);
			if (l) begin
				fcs = crc ^ hbf_pkg::CRC_INIT;
				for (int i = 0; i < 16; i++)
					push_content(fcs[i]);
				for (int i = 0; i < 8; i++)
					push_bit(hbf_pkg::FLAG[i], 1'b0);
				crc = hbf_pkg::CRC_INIT;
				ones = 0;
				in_frame = 0;
			end
			tail = due.pop_back();
			tail.run_last = 1'b1;
			due.push_back(tail);
		endfunction

		function void check_bit(logic b, logic s, logic r);
			line_bit_t want;
			checked++;
			if (due.size() == 0) begin
				report($sformatf("line bit %0d arrived with nothing due", checked));
				return;
			end
			want = due.pop_front();
			if (b !== want.out_bit || s !== want.frame_start || r !== want.run_last)
				report($sformatf("line bit %0d: expected bit/start/last %b/%b/%b, got %b/%b/%b",
					checked, want.out_bit, want.frame_start, want.run_last, b, s, r));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_ready;
	logic [7:0] data_byte;
	logic last_byte;
	logic out_valid;
	logic out_ready;
	logic out_bit;
	logic frame_start;
	logic run_last;

	line_bit_board sb;
	int in_gap_max = 0;
	int out_stall_max = 0;
	int reg_writes = 0;

	hdlc_bit_framer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_bit(out_bit),
		.frame_start(frame_start),
		.run_last(run_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("Timeout: line bits still pending");
		$display("TEST FAILED");
		$finish;
	end

	task automatic drain();
		while (sb.due.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] d, input logic l);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = d;
		last_byte = l;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(d, l);
		@(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		in_valid = 1'b0;
		drain();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == hbf_pkg::ADDR_PREAMBLE)
			sb.set_preamble(data);
		reg_writes++;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = hbf_pkg::ADDR_PREAMBLE;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {27'd0, sb.pre_reg})
			sb.report($sformatf("preamble readback: expected %0d, got %0d", sb.pre_reg, prdata));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1: return 8'hFF;
			2: return 8'h00;
			3, 4: return 8'($urandom() | $urandom());
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic logic [31:0] pick_preamble();
		logic [4:0] v;
		case ($urandom_range(0, 5))
			0: v = 5'd0;
			1: v = 5'd16;
			2: v = 5'd31;
			3: v = 5'($urandom_range(17, 30));
			default: v = 5'($urandom_range(0, 15));
		endcase
		return ($urandom() & 32'hFFFF_FFE0) | {27'd0, v};
	endfunction

	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			int stall;
			stall = $urandom_range(0, out_stall_max);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_bit(out_bit, frame_start, run_last);
			@(negedge clk);
		end
	end

	initial begin
		logic [15:0] fcs;
		logic [7:0] stuff_byte;
		int len;
		int random_bytes;
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = hbf_pkg::ADDR_PREAMBLE;
		pwdata = 32'd0;
		in_valid = 1'b0;
		data_byte = 8'd0;
		last_byte = 1'b0;
		stuff_byte = 8'd0;
		random_bytes = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// find a single-byte frame whose FCS ends in five ones
		for (int b = 0; b < 256; b++) begin
			fcs = line_bit_board::crc_after(hbf_pkg::CRC_INIT, 8'(b)) ^ hbf_pkg::CRC_INIT;
			if (fcs[15:10] == 6'b111110)
				stuff_byte = 8'(b);
		end

		in_gap_max = 12;
		out_stall_max = 12;
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		apb_write(hbf_pkg::ADDR_PREAMBLE, 32'd16);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7E, 1'b0);
		send_byte(8'hF8, 1'b1);
		apb_write(hbf_pkg::ADDR_PREAMBLE, 32'hFFFF_FFFF);
		send_byte(stuff_byte, 1'b1);
		in_gap_max = 0;
		out_stall_max = 0;
		apb_write(hbf_pkg::ADDR_PREAMBLE, 32'd1);
		send_byte(8'h55, 1'b0);
		apb_write(hbf_pkg::ADDR_PREAMBLE, 32'd5);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h01, 1'b1);
		apb_write(ADDR_UNMAPPED, 32'd3);
		send_byte(8'h80, 1'b1);
		apb_write(hbf_pkg::ADDR_PREAMBLE, 32'd17);
		send_byte(8'h3F, 1'b0);
		send_byte(8'hFC, 1'b1);
		apb_write(hbf_pkg::ADDR_PREAMBLE, 32'd0);
		send_byte(8'h1F, 1'b1);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h0F, 1'b1);

		while (random_bytes < 410) begin
			if ($urandom_range(0, 3) == 0) begin
				in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				out_stall_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			end
			if ($urandom_range(0, 4) == 0)
				apb_write(hbf_pkg::ADDR_PREAMBLE, pick_preamble());
			case ($urandom_range(0, 9))
				0: len = $urandom_range(13, 24);
				1, 2, 3: len = $urandom_range(5, 12);
				default: len = $urandom_range(1, 4);
			endcase
			for (int k = 0; k < len; k++) begin
				send_byte(pick_byte(), k == len - 1);
				random_bytes++;
				if (k == 0 && len > 1 && $urandom_range(0, 15) == 0)
					apb_write(hbf_pkg::ADDR_PREAMBLE, pick_preamble());
			end
		end

		in_valid = 1'b0;
		drain();
		repeat (40) @(negedge clk);
		$display("Framed %0d bytes in %0d frames; %0d line bits checked; %0d register writes.",
			sb.bytes_in, sb.frames, sb.checked, reg_writes);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("Mismatches: %0d", sb.errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: hdlc_bit_framer.f
sv/hbf_pkg.sv
sv/hbf_front.sv
sv/hbf_queue.sv
sv/hbf_serializer.sv
sv/hdlc_bit_framer.sv
sv/hbf_checker.sv
tb/tb_top.sv
